@@ rtl/swrr_pkg.sv @@
// ----------------------------------------------------------------------------
// swrr_pkg
// shared constants and codes for the sliding window row ring
// ----------------------------------------------------------------------------
package swrr_pkg;

  localparam int WINDOW     = 128;
  localparam int DIM        = 64;
  localparam int MAX_ROWS   = 32768;
  localparam int RING_WORDS = WINDOW * DIM;
  localparam int ROW_W      = $clog2(WINDOW);
  localparam int COL_W      = $clog2(DIM);
  localparam int ADDR_W     = $clog2(RING_WORDS);
  localparam int CNT_W      = 22;
  localparam int LEN_W      = ADDR_W + 1;

  localparam logic [15:0]      EXP_MASK  = 16'h7f80;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_ROWS * DIM);

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SHAPE = 3'd1;
  localparam logic [2:0] ST_NONFINITE = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 88;

endpackage

@@ rtl/swrr_ram.sv @@
// ----------------------------------------------------------------------------
// swrr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sliding_window_row_ring.sv @@
// ----------------------------------------------------------------------------
// sliding_window_row_ring
// ring of the last WINDOW rows with staged all-or-nothing append
// ----------------------------------------------------------------------------
// One request is taken at a time. A decode, clear or non-final append element
// is done when taken; a chronological read waits in S_READ for the registered
// ring read. A final append element that passes every check copies
// min(rows, WINDOW) rows from the staging memory into the ring, one word per
// cycle; the block takes no request until the copy ends. The result with the
// new position is issued at close. No clearing pass follows reset or clear:
// only rows below the committed position are ever read, and those were written.
// ----------------------------------------------------------------------------
module sliding_window_row_ring (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // element[15:0], start_position[79:16], row_offset[86:80],
  // column[92:87], window_index[99:93], zero fill[103:100]
  input  logic [swrr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  // command[1:0]
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // element_out[15:0], slot[23:16], committed_position[87:24]
  output logic [swrr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [2:0]                        out_tuser
);
  import swrr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [63:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [63:0]       start_r, start_nxt;
  logic              nonfin_r, nonfin_nxt;
  logic              toolong_r, toolong_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [2:0]        ostat_r, ostat_nxt;
  logic [15:0]       oel_r, oel_nxt;
  logic [7:0]        oslot_r, oslot_nxt;
  logic [63:0]       opos_r, opos_nxt;
  logic [LEN_W-1:0]  k_r, k_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ROW_W-1:0]  first_r, first_nxt;
  logic [ROW_W-1:0]  base_r, base_nxt;
  logic              wpend_r, wpend_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;

  logic [15:0]       f_el;
  logic [63:0]       f_start;
  logic [ROW_W-1:0]  f_row;
  logic [COL_W-1:0]  f_col;
  logic [6:0]        f_win;
  logic              acc;

  logic              st_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [15:0]       st_rdata;
  logic [ADDR_W-1:0] rg_raddr, rd_addr_req;
  logic [15:0]       rg_rdata;

  // close checks
  logic [CNT_W-1:0]  c_cnt;
  logic              c_toolong, c_nonfin;
  logic [63:0]       c_start;
  logic [CNT_W-COL_W-1:0] c_rows;
  logic [64:0]       c_sum;
  logic              c_bad;
  logic [ROW_W:0]    c_ret;

  // query helpers
  logic [63:0]       pm1;
  logic [ROW_W:0]    oldest;
  logic [ROW_W-1:0]  dslot;
  logic [ROW_W:0]    avail;
  logic [ROW_W-1:0]  first_row;
  logic [ROW_W-1:0]  src_row;

  assign f_el    = in_tdata[15:0];
  assign f_start = in_tdata[79:16];
  assign f_row   = in_tdata[86:80];
  assign f_col   = in_tdata[92:87];
  assign f_win   = in_tdata[99:93];

  assign in_tready = (state_r == S_IDLE) && !wpend_r && !(ovalid_r && !out_tready);
  assign acc       = in_tvalid && in_tready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {opos_r, oslot_r, oel_r};
  assign out_tuser  = ostat_r;

  // staging store write on each kept append element
  assign st_we    = acc && (in_tuser == CMD_APPEND) && (cnt_r < COUNT_CAP);
  assign st_waddr = cnt_r[ADDR_W-1:0];
  assign src_row  = first_r + k_r[ADDR_W-1:COL_W];
  assign st_raddr = {src_row, k_r[COL_W-1:0]};

  swrr_ram #(.WIDTH(16), .DEPTH(RING_WORDS)) u_stage (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (f_el),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  swrr_ram #(.WIDTH(16), .DEPTH(RING_WORDS)) u_ring (
    .clk   (clk),
    .we    (wpend_r),
    .waddr (waddr_r),
    .wdata (st_rdata),
    .raddr (rg_raddr),
    .rdata (rg_rdata)
  );

  always_comb begin
    avail     = (pos_r < 64'(WINDOW)) ? pos_r[ROW_W:0] : (ROW_W+1)'(WINDOW);
    first_row = (pos_r < 64'(WINDOW)) ? '0 : pos_r[ROW_W-1:0];
    rd_addr_req = {first_row + f_row, f_col};
    rg_raddr  = rd_addr_req;
    pm1       = pos_r - 64'd1;
    oldest    = {1'b0, pm1[ROW_W-1:0]} + (ROW_W+1)'(1);
    dslot     = oldest[ROW_W-1:0] + f_win;

    c_cnt     = (cnt_r < COUNT_CAP) ? cnt_r + CNT_W'(1) : cnt_r;
    c_toolong = toolong_r || (cnt_r >= COUNT_CAP);
    c_nonfin  = nonfin_r || ((f_el & EXP_MASK) == EXP_MASK);
    c_start   = (cnt_r == '0) ? f_start : start_r;
    c_rows    = c_cnt[CNT_W-1:COL_W];
    c_sum     = {1'b0, pos_r} + 65'(c_rows);
    c_bad     = (c_start != pos_r) || c_toolong || (c_cnt[COL_W-1:0] != '0) ||
                (32'(c_rows) > 32'(MAX_ROWS)) || c_sum[64];
    c_ret     = (c_rows < (CNT_W-COL_W)'(WINDOW)) ? c_rows[ROW_W:0]
                                                   : (ROW_W+1)'(WINDOW);
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    start_nxt   = start_r;
    nonfin_nxt  = nonfin_r;
    toolong_nxt = toolong_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ostat_nxt   = ostat_r;
    oel_nxt     = oel_r;
    oslot_nxt   = oslot_r;
    opos_nxt    = opos_r;
    k_nxt       = k_r;
    len_nxt     = len_r;
    first_nxt   = first_r;
    base_nxt    = base_r;
    wpend_nxt   = 1'b0;
    waddr_nxt   = waddr_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_tuser)
            CMD_APPEND: begin
              if (!in_tlast) begin
                cnt_nxt     = c_cnt;
                start_nxt   = c_start;
                nonfin_nxt  = c_nonfin;
                toolong_nxt = c_toolong;
              end else begin
                cnt_nxt     = '0;
                start_nxt   = '0;
                nonfin_nxt  = 1'b0;
                toolong_nxt = 1'b0;
                ovalid_nxt  = 1'b1;
                oel_nxt     = '0;
                oslot_nxt   = '0;
                opos_nxt    = pos_r;
                if (c_bad) begin
                  ostat_nxt = ST_BAD_SHAPE;
                end else if (c_nonfin) begin
                  ostat_nxt = ST_NONFINITE;
                end else begin
                  ostat_nxt = ST_OK;
                  pos_nxt   = c_sum[63:0];
                  opos_nxt  = c_sum[63:0];
                  // rows older than the window wrap, so the first retained
                  // row sits at rows mod WINDOW once rows reach WINDOW
                  first_nxt = (c_ret == (ROW_W+1)'(WINDOW)) ? c_rows[ROW_W-1:0] : '0;
                  base_nxt  = pos_r[ROW_W-1:0];
                  len_nxt   = LEN_W'({c_ret, {COL_W{1'b0}}});
                  k_nxt     = '0;
                  if (c_ret != '0) begin
                    state_nxt = S_COPY;
                  end
                end
              end
            end
            CMD_READ: begin
              if ({1'b0, f_row} >= avail || 32'(f_col) >= 32'(DIM)) begin
                ovalid_nxt = 1'b1;
                ostat_nxt  = ST_RANGE;
                oel_nxt    = '0;
                oslot_nxt  = '0;
                opos_nxt   = pos_r;
              end else begin
                state_nxt = S_READ;
              end
            end
            CMD_DECODE: begin
              ovalid_nxt = 1'b1;
              oel_nxt    = '0;
              oslot_nxt  = '0;
              opos_nxt   = pos_r;
              if (pos_r == '0) begin
                ostat_nxt = ST_EMPTY;
              end else if (32'(f_win) >= 32'(WINDOW)) begin
                ostat_nxt = ST_RANGE;
              end else begin
                ostat_nxt = ST_OK;
                oslot_nxt = (64'(dslot) > pm1) ? 8'hff : 8'(dslot);
              end
            end
            default: begin
              pos_nxt     = '0;
              cnt_nxt     = '0;
              start_nxt   = '0;
              nonfin_nxt  = 1'b0;
              toolong_nxt = 1'b0;
              ovalid_nxt  = 1'b1;
              ostat_nxt   = ST_OK;
              oel_nxt     = '0;
              oslot_nxt   = '0;
              opos_nxt    = '0;
            end
          endcase
        end
      end
      S_READ: begin
        ovalid_nxt = 1'b1;
        ostat_nxt  = ST_OK;
        oel_nxt    = rg_rdata;
        oslot_nxt  = '0;
        opos_nxt   = pos_r;
        state_nxt  = S_IDLE;
      end
      S_COPY: begin
        // staging read issued now, ring write in the next cycle
        wpend_nxt = 1'b1;
        waddr_nxt = {base_r + src_row, k_r[COL_W-1:0]};
        k_nxt     = k_r + LEN_W'(1);
        if (k_r == len_r - LEN_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      cnt_r     <= '0;
      start_r   <= '0;
      nonfin_r  <= 1'b0;
      toolong_r <= 1'b0;
      ovalid_r  <= 1'b0;
      wpend_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      start_r   <= start_nxt;
      nonfin_r  <= nonfin_nxt;
      toolong_r <= toolong_nxt;
      ovalid_r  <= ovalid_nxt;
      wpend_r   <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt;
    oel_r   <= oel_nxt;
    oslot_r <= oslot_nxt;
    opos_r  <= opos_nxt;
    k_r     <= k_nxt;
    len_r   <= len_nxt;
    first_r <= first_nxt;
    base_r  <= base_nxt;
    waddr_r <= waddr_nxt;
  end

  a_copy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken while busy");

  a_ring_write_from_copy: assert property (@(posedge clk) disable iff (!rst_n)
    wpend_r |-> $past(state_r == S_COPY))
    else $error("ring write outside copy");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> ovalid_r)
    else $error("read produced no result");

  a_pos_moves_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != $past(pos_r)) |-> $past(acc && (in_tuser == CMD_CLEAR || in_tlast)))
    else $error("position changed without close or clear");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sliding window row ring: a queue-fed driver
// offers requests with random gaps, a row ring tracker predicts each result
// at request acceptance, and a monitor checks results in order
// ----------------------------------------------------------------------------
module tb_top;
  import swrr_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] elem;
    logic [63:0] start;
    logic        last;
    logic [6:0]  row;
    logic [5:0]  col;
    logic [6:0]  widx;
    bit          use_pos;   // start taken from the tracked position at launch
    bit          pick_row;  // row chosen inside the retained range at launch
    bit          drain;     // wait until every result is back
  } req_t;

  typedef struct {
    logic [2:0]  st;
    logic [15:0] el;
    logic [7:0]  sl;
    logic [63:0] pos;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tlast;
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;

  req_t cur = '{default: '0};
  req_t nx;
  req_t pend_q[$];
  rsp_t rsp_q[$];

  // tracked block state
  logic [15:0] ring_mem[RING_WORDS];
  logic [15:0] stage_mem[RING_WORDS];
  logic [63:0] row_pos;
  int unsigned txn_cnt;
  logic [63:0] txn_start;
  bit txn_bad_elem;
  bit txn_long;

  int errors = 0;
  int cycle = 0;
  int quiet = 0;
  int hold = 0;
  bit gap;
  bit calm;

  assign in_tdata = {4'b0, cur.widx, cur.col, cur.row, cur.start, cur.elem};
  assign in_tlast = cur.last;
  assign in_tuser = cur.cmd;

  sliding_window_row_ring uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic track_request(input req_t r);
    rsp_t o;
    int unsigned rows, kept, first, base, src, dst, cnt, idx, oldest, s;
    o = '{st: ST_OK, el: '0, sl: '0, pos: '0};
    case (r.cmd)
      CMD_APPEND: begin
        if (txn_cnt == 0) txn_start = r.start;
        if ((r.elem & EXP_MASK) == EXP_MASK) txn_bad_elem = 1;
        if (txn_cnt < MAX_ROWS * DIM) begin
          stage_mem[txn_cnt % RING_WORDS] = r.elem;
          txn_cnt++;
        end else begin
          txn_long = 1;
        end
        if (!r.last) return;
        rows = txn_cnt / DIM;
        if (txn_start != row_pos || txn_long || txn_cnt % DIM != 0 ||
            rows > MAX_ROWS || 64'(rows) > ~row_pos) begin
          o.st = ST_BAD_SHAPE;
        end else if (txn_bad_elem) begin
          o.st = ST_NONFINITE;
        end else begin
          kept = rows < WINDOW ? rows : WINDOW;
          first = rows - kept;
          base = 32'(row_pos % WINDOW);
          for (int t = 0; t < kept; t++) begin
            src = ((first + t) % WINDOW) * DIM;
            dst = ((base + (first + t) % WINDOW) % WINDOW) * DIM;
            for (int c = 0; c < DIM; c++) ring_mem[dst + c] = stage_mem[src + c];
          end
          row_pos += rows;
        end
        txn_cnt = 0;
        txn_start = '0;
        txn_bad_elem = 0;
        txn_long = 0;
      end
      CMD_READ: begin
        cnt = row_pos < WINDOW ? 32'(row_pos) : WINDOW;
        if (r.row >= cnt) begin
          o.st = ST_RANGE;
        end else begin
          idx = 32'(((((row_pos - cnt) % WINDOW) + r.row) % WINDOW) * DIM + r.col);
          o.el = ring_mem[idx];
        end
      end
      CMD_DECODE: begin
        if (row_pos == 0) begin
          o.st = ST_EMPTY;
        end else begin
          oldest = 32'((row_pos - 1) % WINDOW + 1);
          s = (oldest + r.widx) % WINDOW;
          o.sl = (s > row_pos - 1) ? 8'hFF : 8'(s);
        end
      end
      default: begin
        foreach (ring_mem[i]) ring_mem[i] = '0;
        row_pos = '0;
        txn_cnt = 0;
        txn_start = '0;
        txn_bad_elem = 0;
        txn_long = 0;
      end
    endcase
    o.pos = row_pos;
    rsp_q = {rsp_q, o};
  endtask

  task automatic add_req(input req_t r);
    pend_q = {pend_q, r};
  endtask

  function automatic req_t blank_req(input logic [1:0] cmd);
    req_t r;
    r.cmd = cmd;
    r.elem = 16'($urandom);
    r.start = {$urandom, $urandom};
    r.last = 1'($urandom);
    r.row = 7'($urandom);
    r.col = 6'($urandom);
    r.widx = 7'($urandom);
    r.use_pos = 0;
    r.pick_row = 0;
    r.drain = 0;
    return r;
  endfunction

  // n elements; bad_at >= 0 puts a nonfinite element there; good start unless wrong
  task automatic add_append(input int n, input bit wrong_start, input int bad_at);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r = blank_req(CMD_APPEND);
      if (i == 0 && !wrong_start) r.use_pos = 1;
      if (i == bad_at) r.elem[14:7] = 8'hFF;
      else if (r.elem[14:7] == 8'hFF) r.elem[7] = 1'b0;
      r.last = (i == n - 1);
      add_req(r);
    end
  endtask

  task automatic add_query(input logic [1:0] cmd, input bit in_range);
    req_t r;
    r = blank_req(cmd);
    r.pick_row = in_range;
    add_req(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_request(cur);
      gap = !calm && ($urandom_range(0, 99) < 27);
      if (!in_tvalid || in_tready) begin
        if (pend_q.size() > 0 && !gap && !(pend_q[0].drain && quiet < 40)) begin
          nx = pend_q.pop_front();
          if (nx.use_pos) nx.start = row_pos;
          if (nx.pick_row && row_pos != 0)
            nx.row = 7'($urandom_range(0, 32'(row_pos < WINDOW ? row_pos : WINDOW) - 1));
          cur <= nx;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (cycle == 600) hold = 700;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle++;
    calm = (cycle > 1500 && cycle < 2300);
    quiet = (rsp_q.size() == 0) ? quiet + 1 : 0;
    if (rst_n && out_tvalid && out_tready) begin
      if (rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h status %0d", out_tdata, out_tuser);
      end else begin
        automatic rsp_t e = rsp_q.pop_front();
        if (out_tuser !== e.st || out_tdata[15:0] !== e.el || out_tdata[23:16] !== e.sl ||
            out_tdata[87:24] !== e.pos) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp st %0d el %h sl %h pos %h got st %0d el %h sl %h pos %h",
                     e.st, e.el, e.sl, e.pos, out_tuser, out_tdata[15:0],
                     out_tdata[23:16], out_tdata[87:24]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int pick;
    req_t r;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    foreach (stage_mem[i]) stage_mem[i] = '0;
    row_pos = '0;
    txn_cnt = 0;
    txn_start = '0;
    txn_bad_elem = 0;
    txn_long = 0;

    // directed: empty queries, shape and start errors, nonfinite, clear mid-append
    add_query(CMD_DECODE, 0);
    add_query(CMD_READ, 0);
    r = blank_req(CMD_APPEND);
    r.elem = 16'h0000; r.last = 1; r.start = '0;
    add_req(r);
    add_append(DIM, 1, -1);
    add_append(DIM, 0, 5);
    r = blank_req(CMD_APPEND);
    r.start = '1; r.elem = 16'hFF7F; r.last = 1;
    add_req(r);
    add_append(DIM, 0, -1);
    r = blank_req(CMD_READ); r.row = 0; r.col = 0; add_req(r);
    r = blank_req(CMD_READ); r.row = 0; r.col = 6'h3F; add_req(r);
    r = blank_req(CMD_READ); r.row = 7'h7F; add_req(r);
    r = blank_req(CMD_DECODE); r.widx = 0; add_req(r);
    r = blank_req(CMD_DECODE); r.widx = 7'h7F; add_req(r);
    add_append(DIM + 3, 0, -1);
    add_append(10, 0, -1);
    pend_q.pop_back();
    add_query(CMD_CLEAR, 0);
    add_append(2 * DIM, 0, -1);
    pend_q[pend_q.size() - 2 * DIM].drain = 1;
    add_query(CMD_READ, 1);
    add_query(CMD_DECODE, 0);

    // a multi-row append
    add_append(3 * DIM, 0, -1);
    add_query(CMD_READ, 1);

    while (pend_q.size() < 1100) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) add_append(DIM * $urandom_range(1, 2), 0, -1);
      else if (pick < 50) add_query(CMD_READ, $urandom_range(0, 9) != 0);
      else if (pick < 75) add_query(CMD_DECODE, 0);
      else if (pick < 78) add_query(CMD_CLEAR, 0);
      else if (pick < 80) add_append($urandom_range(1, 3 * DIM), 0, -1);
      else if (pick < 82) add_append(DIM, 1, -1);
      else if (pick < 84) add_append(DIM, 0, $urandom_range(0, DIM - 1));
      else if (pick < 86) begin
        add_append($urandom_range(1, DIM), 0, -1);
        pend_q.pop_back();
        add_query(CMD_CLEAR, 0);
      end else if (pick < 88) begin
        add_query(CMD_READ, 1);
        pend_q[pend_q.size() - 1].drain = 1;
      end else add_query(CMD_READ, 1);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pend_q.size() == 0);
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (9000) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
